// ===== hdl/value_noise_2d_core_assert.svh =====
// Assertion macros used by the checker file.
`ifndef VALUE_NOISE_2D_CORE_ASSERT_SVH
`define VALUE_NOISE_2D_CORE_ASSERT_SVH

// Same-cycle implication, masked while reset is low.
`define VN2D_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("value noise core: same-cycle check failed");

// Next-cycle implication, masked while reset is low.
`define VN2D_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("value noise core: next-cycle check failed");

// Check that holds while reset is applied.
`define VN2D_ASSERT_RST(lbl, cons) \
	lbl: assert property (@(posedge clk) (!arst_n) |-> (cons)) \
		else $error("value noise core: reset check failed");

`endif

// ===== hdl/vn2d_pkg.sv =====
package vn2d_pkg;

	localparam int INT_BITS       = 12;
	localparam int FRAC_BITS      = 12;
	localparam int COS_TABLE_BITS = 8;

	localparam int COORD_W    = 24;
	localparam int SEED_W     = 31;
	localparam int HASH_W     = 32;
	localparam int NN_W       = 31;
	localparam int WEIGHT_W   = 17;
	localparam int VAL_W      = 18;
	localparam int DIFF_W     = VAL_W + 1;
	localparam int PROD_W     = 37;
	localparam int PIPE_DEPTH = 8;
	localparam int CORNERS    = 4;

	localparam int TABLE_SIZE = 1 << COS_TABLE_BITS;
	localparam int IDX_SHR    = (FRAC_BITS >= COS_TABLE_BITS) ? FRAC_BITS - COS_TABLE_BITS : 0;
	localparam int IDX_SHL    = (COS_TABLE_BITS > FRAC_BITS) ? COS_TABLE_BITS - FRAC_BITS : 0;

	localparam logic [HASH_W-1:0] ROW_MUL  = 32'd57;
	localparam int                XOR_SHL  = 13;
	localparam logic [HASH_W-1:0] SQ_MUL   = 32'd60493;
	localparam logic [HASH_W-1:0] SQ_ADD   = 32'd19990303;
	localparam logic [HASH_W-1:0] OUT_ADD  = 32'd1376312589;
	localparam logic [VAL_W-1:0]  VAL_ONE  = 18'd65536;
	localparam logic [63:0]       PI_Q28   = 64'd843314857;
	localparam longint            ONE_Q28  = longint'(1) << 28;

	typedef logic [TABLE_SIZE-1:0][WEIGHT_W-1:0] weight_tab_t;

	// Advance enables for the hash multiplier stages.
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} hash_adv_t;

	// (1 - cos(pi*i/N))/2 in Q16, Taylor series in Q28.
	function automatic weight_tab_t build_weight_tab();
		weight_tab_t tab;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		longint      c;
		longint      w;
		tab = '0;
		for (int i = 0; i < TABLE_SIZE; i++) begin
			x    = (PI_Q28 * 64'(i)) >> COS_TABLE_BITS;
			x2   = (x * x) >> 28;
			term = 64'(ONE_Q28);
			c    = ONE_Q28;
			for (int k = 1; k <= 12; k++) begin
				term = ((term * x2) >> 28) / 64'((2 * k - 1) * (2 * k));
				if ((k & 1) != 0) begin
					c = c - longint'(term);
				end else begin
					c = c + longint'(term);
				end
			end
			w = (ONE_Q28 - c) + 4096;
			if (w < 0) begin
				w = 0;
			end
			w = w >>> 13;
			if (w > 65536) begin
				w = 65536;
			end
			tab[i] = WEIGHT_W'(w);
		end
		return tab;
	endfunction

	localparam weight_tab_t WEIGHT_TAB = build_weight_tab();

	function automatic logic [COS_TABLE_BITS-1:0] weight_idx(logic [FRAC_BITS-1:0] frac);
		logic [FRAC_BITS+COS_TABLE_BITS-1:0] wide;
		wide = (FRAC_BITS + COS_TABLE_BITS)'(frac);
		return COS_TABLE_BITS'((wide >> IDX_SHR) << IDX_SHL);
	endfunction

	// a + round((b - a) * w / 2^16), half rounds up.
	function automatic logic signed [VAL_W-1:0] blend_out(logic signed [VAL_W-1:0] a,
	                                                      logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] r;
		logic signed [PROD_W-1:0] sum;
		r   = (p + PROD_W'(32768)) >>> 16;
		sum = PROD_W'(a) + r;
		return sum[VAL_W-1:0];
	endfunction

endpackage

// ===== hdl/vn2d_hash.sv =====
module vn2d_hash (
	input  logic                            clk,
	input  vn2d_pkg::hash_adv_t             adv,
	input  logic [vn2d_pkg::HASH_W-1:0]     n_s1,
	output logic [vn2d_pkg::NN_W-1:0]       nn_s4
);

	logic [vn2d_pkg::HASH_W-1:0] n_s2;
	logic [vn2d_pkg::HASH_W-1:0] sq_s2;
	logic [vn2d_pkg::HASH_W-1:0] n_s3;
	logic [vn2d_pkg::HASH_W-1:0] p_s3;
	logic [vn2d_pkg::HASH_W-1:0] sq_d;
	logic [vn2d_pkg::HASH_W-1:0] p_d;
	logic [vn2d_pkg::HASH_W-1:0] nn_d;

	// All products wrap at 32 bits.
	always_comb begin
		sq_d = n_s1 * n_s1;
		p_d  = sq_s2 * vn2d_pkg::SQ_MUL + vn2d_pkg::SQ_ADD;
		nn_d = n_s3 * p_s3 + vn2d_pkg::OUT_ADD;
	end

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			n_s2  <= n_s1;
			sq_s2 <= sq_d;
		end
		if (adv.s3) begin
			n_s3 <= n_s2;
			p_s3 <= p_d;
		end
		if (adv.s4) begin
			nn_s4 <= nn_d[vn2d_pkg::NN_W-1:0];
		end
	end

endmodule

// ===== hdl/value_noise_2d_core.sv =====
// Pipeline: an input transfer passes through stages 1 to 8 (registers s1 to s8),
// and the result sits on m_tdata from the stage 8 output register.
// Throughput: one item per cycle while the output is not stalled; three 32-bit
// multiplier stages per corner hash and two blend multiplier stages set the depth.
// Stall: each stage holds while the one after it is full and held.
// Reset: arst_n clears all valid bits and the seed to zero; no clearing pass.
module value_noise_2d_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [30:0] cfg_wdata,   // noise_seed
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,     // [23:0] coord_x, [47:24] coord_y
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata      // [17:0] noise_value, [23:18] zero
);

	localparam int DEPTH = vn2d_pkg::PIPE_DEPTH;
	localparam int IB    = vn2d_pkg::INT_BITS;
	localparam int FB    = vn2d_pkg::FRAC_BITS;
	localparam int HW    = vn2d_pkg::HASH_W;
	localparam int WW    = vn2d_pkg::WEIGHT_W;
	localparam int VW    = vn2d_pkg::VAL_W;
	localparam int DW    = vn2d_pkg::DIFF_W;
	localparam int PW    = vn2d_pkg::PROD_W;
	localparam int NC    = vn2d_pkg::CORNERS;

	logic [vn2d_pkg::SEED_W-1:0] seed_q;
	logic [DEPTH:1]              vld_q;
	logic [DEPTH:1]              adv;

	logic [vn2d_pkg::COORD_W-1:0] cx;
	logic [vn2d_pkg::COORD_W-1:0] cy;
	logic [IB-1:0]                ix;
	logic [IB-1:0]                iy;
	logic [HW-1:0]                n_d   [NC];
	logic [HW-1:0]                n_s1  [NC];
	logic [vn2d_pkg::NN_W-1:0]    nn_s4 [NC];
	logic signed [VW-1:0]         cval  [NC];

	logic [WW-1:0] wx_s1, wx_s2, wx_s3, wx_s4;
	logic [WW-1:0] wy_s1, wy_s2, wy_s3, wy_s4, wy_s5, wy_s6;

	logic signed [VW-1:0] a_top_s5, a_bot_s5;
	logic signed [PW-1:0] p_top_s5, p_bot_s5;
	logic signed [VW-1:0] top_s6, bot_s6;
	logic signed [VW-1:0] top_s7;
	logic signed [PW-1:0] p_s7;
	logic signed [VW-1:0] noise_s8;

	logic signed [DW-1:0] d_top, d_bot, d_y;
	logic signed [PW-1:0] p_top_d, p_bot_d, p_y_d;

	vn2d_pkg::hash_adv_t hash_adv;

	// Advance a stage when it is empty or its successor advances.
	always_comb begin
		adv[DEPTH] = !vld_q[DEPTH] || m_tready;
		for (int k = DEPTH - 1; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign s_tready = adv[1];
	assign m_tvalid = vld_q[DEPTH];
	assign m_tdata  = {{(24 - VW){1'b0}}, noise_s8};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
			vld_q  <= '0;
		end else begin
			if (cfg_wen) begin
				seed_q <= cfg_wdata;
			end
			if (adv[1]) begin
				vld_q[1] <= s_tvalid;
			end
			for (int k = 2; k <= DEPTH; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// Stage 1: lattice cell, corner hash seeds, weight lookup.
	always_comb begin
		cx = s_tdata[23:0];
		cy = s_tdata[47:24];
		ix = cx[FB +: IB];
		iy = cy[FB +: IB];
		for (int c = 0; c < NC; c++) begin
			logic [HW-1:0] n0;
			n0 = HW'(ix) + HW'(c & 1) + (HW'(iy) + HW'((c >> 1) & 1)) * vn2d_pkg::ROW_MUL
			     + HW'(seed_q);
			n_d[c] = n0 ^ (n0 << vn2d_pkg::XOR_SHL);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			for (int c = 0; c < NC; c++) begin
				n_s1[c] <= n_d[c];
			end
			wx_s1 <= vn2d_pkg::WEIGHT_TAB[vn2d_pkg::weight_idx(cx[FB-1:0])];
			wy_s1 <= vn2d_pkg::WEIGHT_TAB[vn2d_pkg::weight_idx(cy[FB-1:0])];
		end
	end

	// Stages 2 to 4: corner hash multipliers.
	assign hash_adv = '{s2: adv[2], s3: adv[3], s4: adv[4]};

	for (genvar c = 0; c < NC; c++) begin : g_corner
		vn2d_hash u_hash (
			.clk   (clk),
			.adv   (hash_adv),
			.n_s1  (n_s1[c]),
			.nn_s4 (nn_s4[c])
		);
		assign cval[c] = $signed(vn2d_pkg::VAL_ONE - VW'(nn_s4[c][vn2d_pkg::NN_W-1:14]));
	end

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			wx_s2 <= wx_s1;
			wy_s2 <= wy_s1;
		end
		if (adv[3]) begin
			wx_s3 <= wx_s2;
			wy_s3 <= wy_s2;
		end
		if (adv[4]) begin
			wx_s4 <= wx_s3;
			wy_s4 <= wy_s3;
		end
	end

	// Stage 5: corner values and x-blend products; also the y-blend product for stage 7.
	always_comb begin
		d_top   = DW'(cval[1]) - DW'(cval[0]);
		d_bot   = DW'(cval[3]) - DW'(cval[2]);
		p_top_d = PW'(d_top) * PW'($signed({1'b0, wx_s4}));
		p_bot_d = PW'(d_bot) * PW'($signed({1'b0, wx_s4}));
		d_y     = DW'(bot_s6) - DW'(top_s6);
		p_y_d   = PW'(d_y) * PW'($signed({1'b0, wy_s6}));
	end

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			a_top_s5 <= cval[0];
			a_bot_s5 <= cval[2];
			p_top_s5 <= p_top_d;
			p_bot_s5 <= p_bot_d;
			wy_s5    <= wy_s4;
		end
		// Stage 6: finish the x blends.
		if (adv[6]) begin
			top_s6 <= vn2d_pkg::blend_out(a_top_s5, p_top_s5);
			bot_s6 <= vn2d_pkg::blend_out(a_bot_s5, p_bot_s5);
			wy_s6  <= wy_s5;
		end
		// Stage 7: y-blend product.
		if (adv[7]) begin
			top_s7 <= top_s6;
			p_s7   <= p_y_d;
		end
		// Stage 8: output register.
		if (adv[8]) begin
			noise_s8 <= vn2d_pkg::blend_out(top_s7, p_s7);
		end
	end

endmodule

// ===== hdl/vn2d_checker.sv =====
`include "value_noise_2d_core_assert.svh"

module vn2d_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	// A held result keeps its value.
	`VN2D_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// Input side backs up only when a result is waiting and not taken.
	`VN2D_ASSERT_IMP(a_stall_src, !s_tready, m_tvalid && !m_tready)

	// Reset empties the pipeline at once.
	`VN2D_ASSERT_RST(a_reset_empty, !m_tvalid && s_tready)

endmodule

bind value_noise_2d_core vn2d_checker u_vn2d_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
